// ===== rtl/rsr_pkg.sv =====
// Package for the replacement-selection run generator.
// Payload structs, sizes and the sorting-key helper; no dependencies.
`default_nettype none
package rsr_pkg;
	localparam int Capacity = 1024;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);
	localparam int QueueDepth = 2;

	typedef struct packed {
		logic kind;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic new_run;
	} out_t;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Bias the sign bit so that unsigned compare gives signed order.
	function automatic logic [31:0] to_key(input logic [31:0] v);
		to_key = v ^ 32'h8000_0000;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/rsr_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rsr_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/rsr_front.sv =====
// Front end: accepts requests and holds them in a short queue for the engine.
// Uses rsr_pkg.
`default_nettype none
module rsr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire rsr_pkg::in_t in_data,
	output logic q_valid,
	input wire logic q_pop,
	output rsr_pkg::in_t q_data
);
	rsr_pkg::in_t slot_q [rsr_pkg::QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

// ===== rtl/rsr_engine.sv =====
// Back end: heap engine with one RAM port, sifts one heap level at a time.
// Uses rsr_pkg and rsr_ram.
`default_nettype none
module rsr_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire rsr_pkg::in_t q_data,
	output logic out_valid,
	input wire logic out_ready,
	output rsr_pkg::out_t out_data
);
	localparam int AW = rsr_pkg::AddrW;
	localparam int CW = rsr_pkg::CountW;

	localparam logic [4:0] S_IDLE = 5'd0, S_FILLA = 5'd1, S_FILLB = 5'd2, S_FILLC = 5'd3,
		S_UPRD = 5'd4, S_UPWT = 5'd5, S_UPCMP = 5'd6, S_ROOT = 5'd7, S_ROOTW = 5'd8,
		S_STEP = 5'd9, S_LSTW = 5'd10, S_LSTD = 5'd11, S_FRZW = 5'd12, S_FRZD = 5'd13,
		S_DNL = 5'd14, S_DNLW = 5'd15, S_DNR = 5'd16, S_DNRW = 5'd17, S_DNCMP = 5'd18,
		S_DNSW = 5'd19, S_OUT = 5'd20, S_HEAPI = 5'd21, S_DNRD = 5'd22, S_DNRDW = 5'd23;

	logic [4:0] st_q;
	logic [CW-1:0] act_q, frz_q, hi_q;
	logic run_q, flag_q, kind_q, bld_q;
	logic [31:0] key_q, cur_q, lv_q, tmp_q;
	logic [CW-1:0] pos_q, bi_q, hcnt_q;
	logic we;
	logic [AW-1:0] addr;
	logic [31:0] wdata, rdata;
	logic ovalid_q;
	rsr_pkg::out_t odata_q;
	logic [CW:0] lidx, ridx;

	rsr_ram #(.Width(32), .Depth(rsr_pkg::Capacity)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	assign lidx = {pos_q, 1'b1};
	assign ridx = lidx + 1'b1;
	assign out_valid = ovalid_q;
	assign out_data = odata_q;
	assign q_pop = (st_q == S_IDLE) && q_valid && !ovalid_q;

	// RAM port control: address and write data chosen by state
	always_comb begin
		we = 1'b0;
		addr = '0;
		wdata = cur_q;
		unique case (st_q)
			S_FILLA: addr = act_q[AW-1:0];
			S_FILLB: begin
				we = 1'b1;
				addr = hi_q[AW-1:0];
				wdata = rdata;
			end
			S_FILLC: begin
				we = 1'b1;
				addr = act_q[AW-1:0];
				wdata = key_q;
			end
			S_UPRD, S_UPWT: addr = AW'((pos_q - 1'b1) >> 1);
			S_UPCMP: begin
				// parent moves down into the hole, or the new key settles here
				we = 1'b1;
				addr = pos_q[AW-1:0];
				wdata = (rdata > cur_q) ? rdata : cur_q;
			end
			S_ROOT, S_ROOTW: addr = '0;
			S_STEP: begin
				we = 1'b1;
				addr = '0;
				wdata = key_q;
			end
			S_LSTW: addr = hi_q[AW-1:0];
			S_LSTD: begin
				we = 1'b1;
				addr = '0;
				wdata = rdata;
			end
			S_FRZW: addr = AW'(hi_q + frz_q);
			S_FRZD: begin
				we = 1'b1;
				addr = hi_q[AW-1:0];
				wdata = kind_q ? rdata : key_q;
			end
			S_DNRD, S_DNRDW: addr = pos_q[AW-1:0];
			S_DNL, S_DNLW: addr = lidx[AW-1:0];
			S_DNR, S_DNRW: addr = ridx[AW-1:0];
			S_DNSW: begin
				we = 1'b1;
				addr = bi_q[AW-1:0];
				wdata = cur_q;
			end
			S_DNCMP: begin
				we = (bi_q != pos_q) && (lidx < {1'b0, hi_q});
				addr = pos_q[AW-1:0];
				wdata = tmp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (q_pop) key_q <= rsr_pkg::to_key(q_data.value);
			S_FILLA: cur_q <= key_q;
			S_DNRDW: cur_q <= rdata;
			S_DNLW: lv_q <= rdata;
			S_DNRW: begin
				// pick smaller child vs current
				if (ridx < {1'b0, hi_q} && rdata < lv_q && rdata < cur_q) begin
					tmp_q <= rdata;
				end else if (lv_q < cur_q) begin
					tmp_q <= lv_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			act_q <= '0;
			frz_q <= '0;
			run_q <= 1'b0;
			hi_q <= '0;
			pos_q <= '0;
			bi_q <= '0;
			hcnt_q <= '0;
			flag_q <= 1'b0;
			kind_q <= 1'b0;
			bld_q <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_pop) begin
					kind_q <= q_data.kind;
					if (q_data.kind == rsr_pkg::KIND_PUSH && !run_q
							&& (act_q + frz_q) < CW'(rsr_pkg::Capacity)) begin
						hi_q <= act_q + frz_q;
						st_q <= S_FILLA;
					end else if (act_q + frz_q == '0) begin
						run_q <= 1'b0;
					end else if (act_q == '0) begin
						// frozen entries become the next run: heapify
						act_q <= frz_q;
						frz_q <= '0;
						flag_q <= 1'b1;
						bld_q <= 1'b1;
						hcnt_q <= frz_q >> 1;
						st_q <= S_HEAPI;
					end else begin
						flag_q <= !run_q;
						st_q <= S_ROOT;
					end
				end
				S_FILLA: st_q <= (frz_q != '0) ? S_FILLB : S_FILLC;
				S_FILLB: st_q <= S_FILLC;
				S_FILLC: begin
					pos_q <= act_q;
					act_q <= act_q + 1'b1;
					st_q <= (act_q == '0) ? S_IDLE : S_UPRD;
				end
				S_UPRD: st_q <= S_UPWT;
				S_UPWT: st_q <= S_UPCMP;
				S_UPCMP: begin
					if (rdata > cur_q) begin
						pos_q <= (pos_q - 1'b1) >> 1;
						bi_q <= (pos_q - 1'b1) >> 1;
						// at the root the key is written by the swap state
						st_q <= (pos_q <= CW'(2)) ? S_DNSW : S_UPRD;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_HEAPI: begin
					if (hcnt_q == '0) begin
						bld_q <= 1'b0;
						st_q <= S_ROOT;
					end else begin
						pos_q <= hcnt_q - 1'b1;
						hcnt_q <= hcnt_q - 1'b1;
						hi_q <= act_q;
						st_q <= S_DNRD;
					end
				end
				S_ROOT: st_q <= S_ROOTW;
				S_ROOTW: begin
					run_q <= 1'b1;
					hi_q <= act_q - 1'b1;
					if (kind_q == rsr_pkg::KIND_PUSH && key_q >= rdata) begin
						st_q <= S_STEP;
					end else begin
						st_q <= S_LSTW;
					end
				end
				S_STEP: begin
					hi_q <= act_q;
					pos_q <= '0;
					st_q <= S_DNRD;
				end
				S_LSTW: st_q <= S_LSTD;
				S_LSTD: begin
					if (kind_q == rsr_pkg::KIND_PUSH) begin
						st_q <= S_FRZD;
					end else begin
						st_q <= (frz_q != '0) ? S_FRZW : S_OUT;
					end
				end
				S_FRZW: st_q <= S_FRZD;
				S_FRZD: begin
					if (kind_q == rsr_pkg::KIND_PUSH) frz_q <= frz_q + 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: begin
					act_q <= hi_q;
					pos_q <= '0;
					st_q <= S_DNRD;
				end
				S_DNRD: st_q <= S_DNRDW;
				S_DNRDW: st_q <= (lidx < {1'b0, hi_q}) ? S_DNL : S_DNCMP;
				S_DNL: st_q <= S_DNLW;
				S_DNLW: st_q <= S_DNR;
				S_DNR: st_q <= S_DNRW;
				S_DNRW: begin
					if (ridx < {1'b0, hi_q} && rdata < lv_q && rdata < cur_q) begin
						bi_q <= ridx[CW-1:0];
					end else if (lv_q < cur_q) begin
						bi_q <= lidx[CW-1:0];
					end else begin
						bi_q <= pos_q;
					end
					st_q <= S_DNCMP;
				end
				S_DNCMP: begin
					// smaller child moves up to pos; a leaf or no swap keeps cur at pos
					if (bi_q == pos_q || lidx >= {1'b0, hi_q}) bi_q <= pos_q;
					st_q <= S_DNSW;
				end
				S_DNSW: begin
					if (bi_q == pos_q || lidx >= {1'b0, hi_q}) begin
						st_q <= bld_q ? S_HEAPI : S_IDLE;
					end else begin
						pos_q <= bi_q;
						st_q <= S_DNRD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_ROOTW) begin
				ovalid_q <= 1'b1;
				odata_q.value_res <= rsr_pkg::to_key(rdata);
				odata_q.new_run <= flag_q;
			end
			if (st_q == S_OUT && kind_q == rsr_pkg::KIND_DRAIN && hi_q + frz_q == '0) begin
				run_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q + frz_q) <= CW'(rsr_pkg::Capacity)) else $error("store overflow");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == S_IDLE && !ovalid_q)) else $error("pop while busy");
	a_out_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> run_q) else $error("output with no run open");
`endif
endmodule
`default_nettype wire

// ===== rtl/replacement_selection_runs_top.sv =====
// Top level of the replacement-selection run generator.
// Uses rsr_pkg, rsr_front and rsr_engine (which holds rsr_ram).
`default_nettype none
// A push fills a min-heap of rsr_pkg::Capacity entries while no run is open
// and there is room; every other push emits the current minimum and keeps the
// new value in the run or freezes it for the next one. Drain requests emit one
// minimum each until the store is empty, with new_run marking the first output
// of every run. The heap lives in a single-port RAM. An emitting request sinks
// the new root one heap level at a time; a filling push lets the new value rise
// level by level. A run change also rebuilds the heap from the frozen entries,
// one sift per internal node. The engine takes the next request only once the
// output register is empty. The front queue holds two requests so the input
// keeps moving while the engine works, and the output register holds a result
// until it is taken.
module replacement_selection_runs_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire rsr_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output rsr_pkg::out_t out_data
);
	logic q_valid, q_pop;
	rsr_pkg::in_t q_data;

	rsr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

	rsr_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data));
endmodule
`default_nettype wire

// ===== tb/sv/rsr_checker.sv =====
// Checker for the replacement-selection run generator: watches both channels,
// predicts each result with its own heap model and compares. Uses rsr_pkg.
`timescale 1ns / 1ps
module rsr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire rsr_pkg::in_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsr_pkg::out_t out_data,
	output int fail_count,
	output int pending_count
);
	logic [31:0] heap_keys [rsr_pkg::Capacity];
	int unsigned live_cnt;
	int unsigned frozen_cnt;
	bit run_open;
	rsr_pkg::out_t expected_runs [$];

	function automatic void sift_down(int unsigned pos, int unsigned cnt);
		int unsigned least;
		int unsigned l;
		logic [31:0] t;
		forever begin
			least = pos;
			l = 2 * pos + 1;
			if (l < cnt && heap_keys[l] < heap_keys[least])
				least = l;
			if (l + 1 < cnt && heap_keys[l + 1] < heap_keys[least])
				least = l + 1;
			if (least == pos)
				return;
			t = heap_keys[pos];
			heap_keys[pos] = heap_keys[least];
			heap_keys[least] = t;
			pos = least;
		end
	endfunction

	function automatic void sift_up(int unsigned pos);
		int unsigned par;
		logic [31:0] t;
		while (pos > 0) begin
			par = (pos - 1) / 2;
			if (heap_keys[pos] >= heap_keys[par])
				return;
			t = heap_keys[pos];
			heap_keys[pos] = heap_keys[par];
			heap_keys[par] = t;
			pos = par;
		end
	endfunction

	// Advance the model by one request; queue a result if one is due.
	function automatic void predict_run_output(rsr_pkg::in_t req);
		logic [31:0] key;
		logic [31:0] top;
		int unsigned total;
		int unsigned last;
		bit flag;
		rsr_pkg::out_t res;
		key = req.value ^ 32'h8000_0000;
		total = live_cnt + frozen_cnt;
		if (req.kind == rsr_pkg::KIND_PUSH && !run_open && total < rsr_pkg::Capacity) begin
			if (frozen_cnt > 0)
				heap_keys[total] = heap_keys[live_cnt];
			heap_keys[live_cnt] = key;
			sift_up(live_cnt);
			live_cnt++;
			return;
		end
		if (total == 0) begin
			run_open = 0;
			return;
		end
		flag = !run_open;
		if (live_cnt == 0) begin
			// run change: frozen tail becomes the new heap
			live_cnt = frozen_cnt;
			frozen_cnt = 0;
			for (int i = live_cnt / 2; i > 0; i--)
				sift_down(i - 1, live_cnt);
			flag = 1;
		end
		run_open = 1;
		top = heap_keys[0];
		res.value_res = top ^ 32'h8000_0000;
		res.new_run = flag;
		expected_runs.push_back(res);
		last = live_cnt - 1;
		if (req.kind == rsr_pkg::KIND_PUSH) begin
			if (key >= top) begin
				heap_keys[0] = key;
			end else begin
				heap_keys[0] = heap_keys[last];
				heap_keys[last] = key;
				live_cnt = last;
				frozen_cnt++;
			end
			sift_down(0, live_cnt);
		end else begin
			heap_keys[0] = heap_keys[last];
			if (frozen_cnt > 0)
				heap_keys[last] = heap_keys[last + frozen_cnt];
			live_cnt = last;
			sift_down(0, live_cnt);
			if (live_cnt + frozen_cnt == 0)
				run_open = 0;
		end
	endfunction

	assign pending_count = expected_runs.size();

	always @(posedge clk or negedge arst_n) begin
		rsr_pkg::out_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			live_cnt <= 0;
			frozen_cnt <= 0;
			run_open <= 0;
			fail_count <= 0;
			expected_runs.delete();
		end else begin
			if (in_valid && in_ready)
				predict_run_output(in_data);
			if (out_valid && out_ready) begin
				if (expected_runs.size() == 0) begin
					$display("%0t: unexpected result value_res=%0d new_run=%0b", $time,
						out_data.value_res, out_data.new_run);
					errs++;
				end else begin
					want = expected_runs.pop_front();
					if (want.value_res !== out_data.value_res) begin
						$display("%0t: value_res expected %0d actual %0d", $time,
							want.value_res, out_data.value_res);
						errs++;
					end
					if (want.new_run !== out_data.new_run) begin
						$display("%0t: new_run expected %0b actual %0b", $time,
							want.new_run, out_data.new_run);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== tb/sv/tb_replacement_selection_runs_top.sv =====
// Testbench top for replacement_selection_runs_top: drives requests and
// stalls, and gives the verdict. Uses rsr_pkg and rsr_checker.
`timescale 1ns / 1ps
module tb_replacement_selection_runs_top;
	localparam longint CycleLimit = 4_000_000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	rsr_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rsr_pkg::out_t out_data;
	int fail_count;
	int pending_count;
	longint cycle_cnt = 0;
	// receiver long hold-off request from stimulus
	bit hold_req = 0;
	int hold_left = 0;

	always #4 clk = ~clk;

	replacement_selection_runs_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	rsr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Timeout guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: own stall pattern, plus a long hold-off when requested.
	always @(posedge clk) begin
		int mode;
		mode = int'((cycle_cnt / 300) % 4);
		if (hold_req && hold_left == 0)
			hold_left <= 3000;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (mode == 0)
			out_ready <= 1;
		else if (mode == 1)
			out_ready <= ($urandom_range(0, 3) != 0);
		else if (mode == 2)
			out_ready <= ($urandom_range(0, 3) == 0);
		else
			out_ready <= cycle_cnt[2];
	end

	int burst_left = 0;

	// Offer one request and hold it until accepted; bursts with random gaps.
	// Valid stays high after acceptance so the next request can follow at once.
	task automatic send_request(input logic kind, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		in_data.kind <= kind;
		in_data.value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every expected result has come.
	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	// One sort session: n pushes, then enough drains to empty the store.
	task automatic session(input int n);
		for (int i = 0; i < n; i++)
			send_request(rsr_pkg::KIND_PUSH, rand_value());
		for (int i = 0; i < ((n < rsr_pkg::Capacity) ? n : rsr_pkg::Capacity) + 1; i++)
			send_request(rsr_pkg::KIND_DRAIN, $urandom);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: drain on empty store, extremes, equal values
		send_request(rsr_pkg::KIND_DRAIN, 32'h0);
		send_request(rsr_pkg::KIND_PUSH, 32'h7FFF_FFFF);
		send_request(rsr_pkg::KIND_PUSH, 32'h8000_0000);
		send_request(rsr_pkg::KIND_PUSH, 32'h0);
		send_request(rsr_pkg::KIND_PUSH, 32'hFFFF_FFFF);
		send_request(rsr_pkg::KIND_DRAIN, 32'h0);
		// push into an open run with room (replace and freeze)
		send_request(rsr_pkg::KIND_PUSH, 32'h0000_0005);
		send_request(rsr_pkg::KIND_PUSH, 32'h8000_0001);
		send_request(rsr_pkg::KIND_PUSH, 32'h0000_0005);
		for (int i = 0; i < 6; i++)
			send_request(rsr_pkg::KIND_DRAIN, 32'hFFFF_FFFF);
		wait_drained();
		// Small random sessions with run changes
		for (int s = 0; s < 6; s++)
			session($urandom_range(1, 20));
		// Sender pauses until all results are in
		wait_drained();
		// Partial fill, open a run, then replacement steps while the receiver holds off
		for (int i = 0; i < 100; i++)
			send_request(rsr_pkg::KIND_PUSH, rand_value());
		send_request(rsr_pkg::KIND_DRAIN, 32'h0);
		wait_drained();
		hold_req = 1;
		while (hold_left == 0) @(posedge clk);
		hold_req = 0;
		for (int i = 0; i < 120; i++)
			send_request(rsr_pkg::KIND_PUSH, rand_value());
		for (int i = 0; i < 100; i++)
			send_request(rsr_pkg::KIND_DRAIN, 32'h0);
		for (int s = 0; s < 3; s++)
			session($urandom_range(2, 30));
		wait_drained();
		repeat (3000) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
